// ===== sv/xzip_pkg.sv =====
// Shared types and constants for the xz index parser.
// No dependencies; imported by every xzip module.
package xzip_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 9;
  localparam int unsigned SIZE_W           = 63;
  localparam int unsigned LEN_W            = 4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_CRC       = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  localparam logic [SIZE_W-1:0] MAX63 = '1;

  typedef enum logic [4:0] {
    PH_INDICATOR = 5'b00001,
    PH_COUNT     = 5'b00010,
    PH_RECORDS   = 5'b00100,
    PH_TAIL      = 5'b01000,
    PH_SINK      = 5'b10000
  } phase_t;

  // One byte handed from the input register to the processing logic.
  typedef struct packed {
    logic       go;
    logic [7:0] data;
    logic       last;
  } step_t;

  // Delay line / CRC information for the parser.
  typedef struct packed {
    logic       evicted;
    logic [7:0] ev_byte;
    logic       crc_ok;
  } crc_info_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SIZE_W-1:0] total_size;
    logic [SIZE_W-1:0] record_count;
  } result_t;

endpackage

// ===== sv/xzip_in_stage.sv =====
// Input register for the xz index parser byte channel.
// Depends on xzip_pkg (step_t).
module xzip_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_last,
  input  logic           out_free,
  output xzip_pkg::step_t step
);
  import xzip_pkg::*;

  logic       vld_r;
  logic [7:0] data_r;
  logic       last_r;
  logic       go;

  // A final byte needs room in the result register; others always proceed.
  assign go       = vld_r && (!last_r || out_free);
  assign in_ready = !vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (go) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  assign step.go   = go;
  assign step.data = data_r;
  assign step.last = last_r;

  a_go_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> vld_r) else $error("step issued without a held byte");
  a_hold_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !go |=> vld_r && $stable(data_r) && $stable(last_r))
    else $error("held byte lost while stalled");

endmodule

// ===== sv/xzip_crc_unit.sv =====
// Four-byte delay line and CRC-32 register for the xz index tail check.
// Depends on xzip_pkg (step_t, crc_info_t).
module xzip_crc_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  xzip_pkg::step_t      step,
  output xzip_pkg::crc_info_t  info
);
  import xzip_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  dl_r [4];
  logic [7:0]  dl_nxt [4];
  logic [2:0]  fill_r, fill_nxt;
  logic        full;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

  assign full = (fill_r >= 3'd4);

  always_comb begin
    crc_nxt  = crc_r;
    fill_nxt = fill_r;
    for (int i = 0; i < 4; i++) begin
      dl_nxt[i] = dl_r[i];
    end
    if (full) begin
      crc_nxt   = crc_byte(crc_r, dl_r[0]);
      dl_nxt[0] = dl_r[1];
      dl_nxt[1] = dl_r[2];
      dl_nxt[2] = dl_r[3];
      dl_nxt[3] = step.data;
    end else begin
      dl_nxt[fill_r[1:0]] = step.data;
      fill_nxt            = fill_r + 3'd1;
    end
  end

  assign info.evicted = full;
  assign info.ev_byte = dl_r[0];
  // Stored CRC is the last four bytes, little-endian.
  assign info.crc_ok  = ((crc_nxt ^ 32'hFFFFFFFF) ==
                         {dl_nxt[3], dl_nxt[2], dl_nxt[1], dl_nxt[0]});

  always_ff @(posedge clk) begin
    if (!rst_n || (step.go && step.last)) begin
      crc_r  <= 32'hFFFFFFFF;
      fill_r <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        dl_r[i] <= 8'd0;
      end
    end else if (step.go) begin
      crc_r  <= crc_nxt;
      fill_r <= fill_nxt;
      for (int i = 0; i < 4; i++) begin
        dl_r[i] <= dl_nxt[i];
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'd4) else $error("delay line fill out of range");
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.last |=> fill_r == 3'd0 && crc_r == 32'hFFFFFFFF)
    else $error("CRC state not cleared after final byte");

endmodule

// ===== sv/xzip_parse.sv =====
// Index parser: indicator, record count varint, record varints, tail checks.
// Depends on xzip_pkg (phase_t, step_t, crc_info_t, result_t, status codes).
module xzip_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  xzip_pkg::step_t     step,
  input  xzip_pkg::crc_info_t info,
  output xzip_pkg::result_t   res
);
  import xzip_pkg::*;

  localparam logic [LEN_W-1:0] VMAX = LEN_W'(MAX_VARINT_BYTES);

  phase_t            phase_r, phase_nxt;
  logic [SIZE_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SIZE_W-1:0] left_r, left_nxt;
  logic              half_r, half_nxt;
  logic [SIZE_W-1:0] sum_r, sum_nxt;
  logic [SIZE_W-1:0] count_r, count_nxt;
  logic [3:0]        tlen_r, tlen_nxt;
  logic              tnz_r, tnz_nxt;
  logic [1:0]        err_r, err_nxt;

  // Varint step on the current byte
  logic [6:0]        v_sh;
  logic [63:0]       v_shifted;
  logic [SIZE_W-1:0] v_acc;
  logic [LEN_W-1:0]  v_len;
  logic              v_done;
  logic [SIZE_W-1:0] v_val;
  logic [SIZE_W:0]   v_sum;

  assign v_sh      = {3'd0, len_r} * 7'd7;
  assign v_shifted = {57'd0, step.data[6:0]} << v_sh[5:0];
  assign v_acc     = acc_r | v_shifted[SIZE_W-1:0];
  assign v_len     = len_r + LEN_W'(1);
  assign v_done    = !step.data[7] || (v_len >= VMAX);
  // Too-long varint decodes as zero.
  assign v_val     = step.data[7] ? '0 : v_acc;
  assign v_sum     = {1'b0, sum_r} + {1'b0, v_val};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    half_nxt  = half_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    tlen_nxt  = tlen_r;
    tnz_nxt   = tnz_r;
    err_nxt   = err_r;
    res       = '0;
    if (step.go) begin
      unique case (phase_r)
        PH_INDICATOR: begin
          if (step.data != 8'd0) begin
            if (err_nxt == ST_OK) err_nxt = ST_MALFORMED;
            phase_nxt = PH_SINK;
          end else begin
            phase_nxt = PH_COUNT;
          end
        end
        PH_COUNT: begin
          acc_nxt = v_acc;
          len_nxt = v_len;
          if (v_done) begin
            acc_nxt   = '0;
            len_nxt   = '0;
            count_nxt = v_val;
            left_nxt  = v_val;
            half_nxt  = 1'b0;
            phase_nxt = (v_val == '0) ? PH_TAIL : PH_RECORDS;
          end
        end
        PH_RECORDS: begin
          acc_nxt = v_acc;
          len_nxt = v_len;
          if (v_done) begin
            acc_nxt = '0;
            len_nxt = '0;
            if (half_r) begin
              if (v_sum[SIZE_W]) begin
                if (err_nxt == ST_OK) err_nxt = ST_OVERFLOW;
                sum_nxt = MAX63;
              end else begin
                sum_nxt = v_sum[SIZE_W-1:0];
              end
              left_nxt = left_r - SIZE_W'(1);
              if (left_nxt == '0) phase_nxt = PH_TAIL;
            end
            half_nxt = ~half_r;
          end
        end
        PH_TAIL: begin
          // Past the fourth tail byte, the evicted byte is padding.
          if (tlen_r >= 4'd4 && info.evicted && info.ev_byte != 8'd0) tnz_nxt = 1'b1;
          tlen_nxt = tlen_r + 4'd1;
          if (tlen_nxt > 4'd7) begin
            if (err_nxt == ST_OK) err_nxt = ST_MALFORMED;
            phase_nxt = PH_SINK;
          end
        end
        PH_SINK: ;
        default: ;
      endcase

      if (step.last) begin
        if (phase_nxt != PH_TAIL || tlen_nxt < 4'd4 || tlen_nxt > 4'd7 || tnz_nxt) begin
          if (err_nxt == ST_OK) err_nxt = ST_MALFORMED;
        end
        if (err_nxt == ST_OK && !info.crc_ok) err_nxt = ST_CRC;
        res.status       = err_nxt;
        res.total_size   = sum_nxt;
        res.record_count = count_nxt;
        phase_nxt = PH_INDICATOR;
        acc_nxt   = '0;
        len_nxt   = '0;
        left_nxt  = '0;
        half_nxt  = 1'b0;
        sum_nxt   = '0;
        count_nxt = '0;
        tlen_nxt  = 4'd0;
        tnz_nxt   = 1'b0;
        err_nxt   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INDICATOR;
      acc_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      half_r  <= 1'b0;
      sum_r   <= '0;
      count_r <= '0;
      tlen_r  <= 4'd0;
      tnz_r   <= 1'b0;
      err_r   <= ST_OK;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      half_r  <= half_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      tlen_r  <= tlen_nxt;
      tnz_r   <= tnz_nxt;
      err_r   <= err_nxt;
    end
  end

  a_malformed_sinks: assert property (@(posedge clk) disable iff (!rst_n)
    err_r == ST_MALFORMED |-> phase_r == PH_SINK)
    else $error("malformed latched while still parsing");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.last |=> phase_r == PH_INDICATOR && err_r == ST_OK && tlen_r == 4'd0)
    else $error("parser state not cleared after final byte");
  a_tail_len: assert property (@(posedge clk) disable iff (!rst_n)
    tlen_r <= 4'd8) else $error("tail length out of range");
  a_varint_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r < VMAX) else $error("varint length past limit");

endmodule

// ===== sv/xz_index_parser_top.sv =====
// Top level of the xz index parser: input register, parser, CRC unit, result register.
// Depends on xzip_pkg, xzip_in_stage, xzip_crc_unit, xzip_parse.
//
//  channel | ports                                            | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid, in_ready, in_data_byte, in_last         | in
//  result  | out_valid, out_ready, out_status, out_total_size, | out
//          | out_record_count                                  |
//
// One byte per cycle unless a held result blocks a final byte; the parser and CRC
// logic take each byte combinationally from the input register. A result is
// registered when the final byte leaves the input register.
// Reset (rst_n low, synchronous) clears the input, parser, CRC and result state.
// A held result stalls only a following final byte; other bytes keep flowing.
module xz_index_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [62:0] out_total_size,
  output logic [62:0] out_record_count
);
  import xzip_pkg::*;

  step_t     step;
  crc_info_t info;
  result_t   res;
  logic      out_vld_r;
  result_t   out_r;
  logic      out_free;

  assign out_free = !out_vld_r || out_ready;

  xzip_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .out_free     (out_free),
    .step         (step)
  );

  xzip_crc_unit u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .info  (info)
  );

  xzip_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .info  (info),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step.go && step.last) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go && step.last) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_r.status;
  assign out_total_size   = out_r.total_size;
  assign out_record_count = out_r.record_count;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.last |-> out_free)
    else $error("result register overwritten before transfer");
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    step.go && step.last |=> out_vld_r)
    else $error("final byte produced no result");

endmodule

// ===== test/xzip_tb_pkg.sv =====
// Helpers shared by the xz index parser testbench: byte-wise CRC-32 update.
// No dependencies; imported by the checker and by tb.
package xzip_tb_pkg;

  // Reflected CRC-32, poly 0xEDB88320; caller applies init and final inversion.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== test/xzip_checker.sv =====
// Checker for the xz index parser: predicts each result from the accepted input
// bytes and compares it with the result channel. Depends on xzip_pkg, xzip_tb_pkg.
module xzip_checker
  import xzip_pkg::*;
  import xzip_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [62:0] out_total_size,
  input  logic [62:0] out_record_count,
  output int          errors,
  output int          pending
);

  // parser state as the predictor sees it
  phase_t      ph;
  logic [63:0] acc;
  int          acc_len;
  logic [63:0] recs_left;
  bit          odd_half;
  logic [63:0] total;
  logic [63:0] declared;
  logic [31:0] crc;
  logic [7:0]  window [4];
  int          window_fill;
  int          tail_len;
  bit          tail_nz;
  logic [1:0]  err;

  result_t results_due [$];

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_state();
    ph = PH_INDICATOR;
    acc = '0;
    acc_len = 0;
    recs_left = '0;
    odd_half = 0;
    total = '0;
    declared = '0;
    crc = '1;
    for (int i = 0; i < 4; i++) window[i] = 8'h00;
    window_fill = 0;
    tail_len = 0;
    tail_nz = 0;
    err = ST_OK;
  endtask

  task automatic flag(input logic [1:0] code);
    if (err == ST_OK) err = code;
    if (code == ST_MALFORMED) ph = PH_SINK;
  endtask

  task automatic take_varint(input logic [7:0] b, output bit done, output logic [63:0] val);
    int sh;
    sh = (acc_len * 7) % 64;
    acc |= {57'd0, b[6:0]} << sh;
    acc_len++;
    // nine continuation bytes in a row end the varint with value zero
    done = !b[7] || (acc_len >= MAX_VARINT_BYTES);
    val = b[7] ? 64'd0 : acc;
    if (done) begin
      acc = '0;
      acc_len = 0;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [7:0]  ev;
    bit          ev_valid;
    bit          done;
    logic [63:0] v;
    logic [63:0] s;
    result_t     want;
    ev = 8'h00;
    ev_valid = 0;
    // the four newest bytes stay out of the CRC
    if (window_fill >= 4) begin
      ev_valid = 1;
      ev = window[0];
      crc = crc32_byte(crc, window[0]);
      window[0] = window[1];
      window[1] = window[2];
      window[2] = window[3];
      window[3] = b;
    end else begin
      window[window_fill] = b;
      window_fill++;
    end
    case (ph)
      PH_INDICATOR: begin
        if (b != 8'h00) flag(ST_MALFORMED);
        else ph = PH_COUNT;
      end
      PH_COUNT: begin
        take_varint(b, done, v);
        if (done) begin
          declared = {1'b0, v[62:0]};
          recs_left = declared;
          odd_half = 0;
          if (recs_left == 0) ph = PH_TAIL;
          else ph = PH_RECORDS;
        end
      end
      PH_RECORDS: begin
        take_varint(b, done, v);
        if (done) begin
          if (odd_half) begin
            s = total + v;
            if (s > {1'b0, MAX63} || s < total) begin
              flag(ST_OVERFLOW);
              s = {1'b0, MAX63};
            end
            total = s;
            recs_left--;
            if (recs_left == 0) ph = PH_TAIL;
          end
          odd_half = !odd_half;
        end
      end
      PH_TAIL: begin
        // byte leaving the window while the tail is past four is padding
        if (tail_len >= 4 && ev_valid && ev != 8'h00) tail_nz = 1;
        tail_len++;
        if (tail_len > 7) flag(ST_MALFORMED);
      end
      default: ;
    endcase
    if (last) begin
      if (ph != PH_TAIL || tail_len < 4 || tail_len > 7 || tail_nz) flag(ST_MALFORMED);
      if (err == ST_OK && ~crc != {window[3], window[2], window[1], window[0]}) err = ST_CRC;
      want.status = err;
      want.total_size = total[62:0];
      want.record_count = declared[62:0];
      results_due.push_back(want);
      clear_state();
    end
  endtask

  task automatic check_result();
    result_t want;
    if (results_due.size() == 0) begin
      report($sformatf("unexpected result: status %0d total %0d count %0d",
                       out_status, out_total_size, out_record_count));
    end else begin
      want = results_due.pop_front();
      if (out_status != want.status)
        report($sformatf("status %0d, want %0d", out_status, want.status));
      if (out_total_size != want.total_size)
        report($sformatf("total_size %0d, want %0d", out_total_size, want.total_size));
      if (out_record_count != want.record_count)
        report($sformatf("record_count %0d, want %0d", out_record_count, want.record_count));
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
    clear_state();
  end

  // sampled mid-cycle: what is seen here transfers at the next rising edge
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (in_valid && in_ready) predict_byte(in_data_byte, in_last);
      if (out_valid && out_ready) check_result();
    end
    pending = results_due.size();
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for xz_index_parser_top: builds xz index byte streams, directed
// and random, and gives the verdict. Depends on xzip_pkg, xzip_tb_pkg, xzip_checker.
module tb;
  import xzip_pkg::*;
  import xzip_tb_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_BYTES = 250;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [62:0] out_total_size;
  logic [62:0] out_record_count;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;
  int bytes_sent;
  int idle_by_phase [4]  = '{0, 86, 0, 35};
  int stall_by_phase [4] = '{0, 0, 86, 35};

  logic [7:0] frame [$];

  always #5 clk = ~clk;

  xz_index_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_total_size   (out_total_size),
    .out_record_count (out_record_count)
  );

  xzip_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_total_size   (out_total_size),
    .out_record_count (out_record_count),
    .errors           (fail_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit l);
    bit took;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last <= l;
    took = 0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic append_crc();
    logic [31:0] c;
    c = '1;
    foreach (frame[i]) c = crc32_byte(c, frame[i]);
    c = ~c;
    frame.push_back(c[7:0]);
    frame.push_back(c[15:8]);
    frame.push_back(c[23:16]);
    frame.push_back(c[31:24]);
  endtask

  task automatic put_varint(input logic [62:0] v, input bit too_long,
                            output logic [62:0] decoded);
    int n;
    int len;
    if (too_long) begin
      repeat (MAX_VARINT_BYTES) frame.push_back({1'b1, 7'($urandom)});
      decoded = '0;
    end else begin
      n = 1;
      while (n < MAX_VARINT_BYTES && (v >> (7 * n)) != 0) n++;
      len = n;
      // occasionally a non-minimal encoding with zero high groups
      if (n < MAX_VARINT_BYTES && $urandom_range(9) == 0)
        len = $urandom_range(MAX_VARINT_BYTES, n + 1);
      for (int i = 0; i < len; i++) frame.push_back({i != len - 1, 7'(v >> (7 * i))});
      decoded = v;
    end
  endtask

  task automatic build_good();
    logic [62:0] cnt;
    logic [62:0] dec;
    logic [62:0] sz;
    logic [62:0] unused;
    int          sel;
    frame.delete();
    frame.push_back(8'h00);
    cnt = ($urandom_range(9) == 0) ? 63'($urandom_range(8, 5)) : 63'($urandom_range(4, 0));
    put_varint(cnt, $urandom_range(29) == 0, dec);
    for (int r = 0; r < dec; r++) begin
      put_varint(63'($urandom_range(70000, 1)), $urandom_range(39) == 0, unused);
      sel = $urandom_range(9);
      if (sel < 5) sz = 63'($urandom_range(300, 0));
      else if (sel < 8) sz = 63'($urandom);
      else if (sel < 9) sz = 63'({$urandom, $urandom});
      else sz = MAX63;
      put_varint(sz, $urandom_range(39) == 0, unused);
    end
    repeat ($urandom_range(3, 0)) frame.push_back(8'h00);
    append_crc();
  endtask

  // mostly well-formed indexes, the rest damaged or plain noise
  task automatic random_index();
    int roll;
    int k;
    int bitpos;
    build_good();
    roll = $urandom_range(99);
    if (roll < 65) begin
    end else if (roll < 73) begin
      k = $urandom_range(frame.size() - 1, 0);
      bitpos = $urandom_range(7, 0);
      frame[k][bitpos] = ~frame[k][bitpos];
    end else if (roll < 81) begin
      k = $urandom_range(frame.size() - 2, 0);
      frame = frame[0:k];
    end else if (roll < 87) begin
      repeat ($urandom_range(4, 1)) frame.push_back(8'($urandom));
    end else if (roll < 93) begin
      repeat (4) void'(frame.pop_back());
      frame.push_back(8'($urandom_range(255, 1)));
      append_crc();
    end else begin
      frame.delete();
      repeat ($urandom_range(12, 1)) frame.push_back(8'($urandom));
    end
    send_frame();
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_last = 1'b0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    bytes_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty index, valid CRC
    frame = '{8'h00, 8'h00};
    append_crc();
    send_frame();
    // bad indicator, all-ones byte, last at once
    frame = '{8'hFF};
    send_frame();
    // empty index with wrong CRC
    frame = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // last in the middle of the records
    frame = '{8'h00, 8'h01, 8'h00};
    send_frame();
    // nonzero padding byte
    frame = '{8'h00, 8'h00, 8'h01};
    append_crc();
    send_frame();
    wait_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) random_index();
      wait_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/xzip_pkg.sv
sv/xzip_in_stage.sv
sv/xzip_crc_unit.sv
sv/xzip_parse.sv
sv/xz_index_parser_top.sv
test/xzip_tb_pkg.sv
test/xzip_checker.sv
test/tb.sv
